// File: rtl/core/pess_pkg.sv
// shared types and constants for the periodic event slot scheduler
package pess_pkg;
  localparam int unsigned SLOTS_DEF   = 10;
  localparam int unsigned CNT_W       = 14;
  localparam int unsigned NAME_W      = 64;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned PER_W       = 16;
  localparam int unsigned HND_W       = 16;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned QDEPTH      = 2;
  localparam logic [CNT_W-1:0] WRAP_RESET = 14'd10000;
  localparam logic [LEN_W-1:0] NAME_LIMIT = 8'd31;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_REG  = 2'd1,
    KIND_DEL  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_NAME = 2'd1,
    ERR_NOT_FND  = 2'd2
  } err_t;

  typedef struct packed {
    kind_t             kind;
    logic [NAME_W-1:0] name_tag;
    logic              name_ok;
    logic [PER_W-1:0]  period;
    logic [HND_W-1:0]  handler_tag;
  } cmd_t;

  typedef struct packed {
    logic              fired;
    logic [SLOT_W-1:0] slot;
    logic [HND_W-1:0]  handler;
    err_t              error_code;
    logic              last;
  } res_t;
endpackage

// File: rtl/core/pess_front.sv
// front end: classifies requests and queues them for the back end
module pess_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_kind,
  input  logic [63:0]        in_name_tag,
  input  logic [7:0]         in_name_length,
  input  logic [15:0]        in_period,
  input  logic [15:0]        in_handler_tag,
  output logic               cmd_valid,
  input  logic               cmd_take,
  output pess_pkg::cmd_t     cmd
);
  pess_pkg::cmd_t q_r [pess_pkg::QDEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       acc, keep;
  pess_pkg::cmd_t c_in;

  assign full  = (cnt_r == 2'(pess_pkg::QDEPTH));
  assign acc   = push && !full;
  // kind 3 produces nothing, drop it here
  assign keep  = acc && (pess_pkg::kind_t'(in_kind) != pess_pkg::KIND_NONE);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rp_r];

  always_comb begin
    c_in.kind        = pess_pkg::kind_t'(in_kind);
    c_in.name_tag    = in_name_tag;
    c_in.name_ok     = (in_name_length < pess_pkg::NAME_LIMIT);
    c_in.period      = in_period;
    c_in.handler_tag = in_handler_tag;
    cnt_nxt = cnt_r + 2'(keep) - 2'(cmd_take && cmd_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (keep) wp_r <= ~wp_r;
      if (cmd_take && cmd_valid) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) q_r[wp_r] <= c_in;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(pess_pkg::QDEPTH)) else $error("queue count overflow");
  a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !(cmd_take && cmd_valid)) else $error("take while empty");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wp_r == rp_r)) else $error("ptr mismatch");
endmodule

// File: rtl/core/pess_back.sv
// back end: slot table, tick counter with serial modulo, result register
module pess_back #(
  parameter int unsigned SLOTS = pess_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  pess_pkg::cmd_t     cmd,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [13:0]        cfg_wrap_limit,
  output logic               res_valid,
  input  logic               res_pop,
  output pess_pkg::res_t     res
);
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SW = pess_pkg::SLOT_W;
  localparam int unsigned CW = pess_pkg::CNT_W;
  localparam int unsigned PW = pess_pkg::PER_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_NEXT = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [SLOTS-1:0]  act_r;
  logic [63:0]       name_r [SLOTS];
  logic [PW-1:0]     per_r  [SLOTS];
  logic [15:0]       hnd_r  [SLOTS];
  logic [CW-1:0]     cnt_r, wrap_r;
  logic [IW-1:0]     idx_r;
  logic [CW-1:0]     rem_r;
  logic [3:0]        bit_r;
  logic              pend_r;
  logic [IW-1:0]     pend_idx_r;
  logic              out_v_r;
  pess_pkg::res_t    out_r;
  logic [CW:0]       rsh;
  logic [PW:0]       rsh_w, diff;
  logic [CW-1:0]     inc;
  logic              free_f;
  logic [IW-1:0]     free_i;
  logic [SLOTS-1:0]  hit;
  logic              out_free, last_idx, divides, eligible;

  assign cfg_ready = (state_r == ST_IDLE) && !cmd_valid;
  assign res_valid = out_v_r;
  assign res = out_r;
  assign out_free = !out_v_r || res_pop;
  assign inc = cnt_r + CW'(1);
  assign last_idx = (idx_r == IW'(SLOTS - 1));

  // restoring division step on the tick count
  always_comb begin
    rsh   = {rem_r, cnt_r[bit_r]};
    rsh_w = {{(PW-CW){1'b0}}, rsh};
    diff  = rsh_w - {1'b0, per_r[idx_r]};
  end

  assign divides = (rem_r == '0);
  assign eligible = act_r[idx_r] && (per_r[idx_r] != '0);

  always_comb begin
    free_f = 1'b0;
    free_i = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_f = 1'b1;
        free_i = IW'(i);
      end
    end
    for (int i = 0; i < SLOTS; i++) hit[i] = act_r[i] && (name_r[i] == cmd.name_tag);
  end

  assign cmd_take = (state_r == ST_IDLE) && cmd_valid && out_free && !pend_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (cmd_take && cmd.kind == pess_pkg::KIND_TICK) state_nxt = ST_NEXT;
      ST_NEXT: state_nxt = eligible ? ST_DIV : (last_idx ? ST_EMIT : ST_NEXT);
      ST_DIV:  if (bit_r == '0) state_nxt = ST_EMIT;
      ST_EMIT: if (out_free) state_nxt = last_idx ? ST_IDLE : ST_NEXT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      act_r   <= '0;
      cnt_r   <= '0;
      wrap_r  <= pess_pkg::WRAP_RESET;
      out_v_r <= 1'b0;
      pend_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_v_r && res_pop) out_v_r <= 1'b0;
      if (cfg_valid && cfg_ready) wrap_r <= cfg_wrap_limit;
      case (state_r)
        ST_IDLE: begin
          if (cmd_take) begin
            case (cmd.kind)
              pess_pkg::KIND_TICK: begin
                cnt_r <= inc;
                idx_r <= '0;
              end
              pess_pkg::KIND_REG: begin
                if (free_f) begin
                  act_r[free_i] <= 1'b1;
                  out_v_r <= 1'b1;
                end
              end
              pess_pkg::KIND_DEL: begin
                act_r <= act_r & ~hit;
                out_v_r <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_NEXT: begin
          if (!eligible) begin
            if (!last_idx) idx_r <= idx_r + IW'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (pend_r && divides && eligible) begin
              // current slot also fires, so earlier one is not last
            end
            if (pend_r && (!eligible || !divides) && last_idx) begin
              out_v_r <= 1'b1;
              pend_r  <= 1'b0;
            end else if (pend_r && eligible && divides) begin
              out_v_r <= 1'b1;
              pend_r  <= 1'b1;
              pend_idx_r <= idx_r;
            end else if (pend_r) begin
              pend_r <= 1'b1;
            end else if (eligible && divides) begin
              pend_r <= 1'b1;
              pend_idx_r <= idx_r;
            end
            if (last_idx) begin
              if (cnt_r >= wrap_r) cnt_r <= '0;
              if (pend_r && eligible && divides) pend_r <= 1'b1;
            end else begin
              idx_r <= idx_r + IW'(1);
            end
          end
        end
        default: ;
      endcase
      // flush final pending firing once the walk is done
      if (state_r == ST_IDLE && pend_r && out_free) begin
        out_v_r <= 1'b1;
        pend_r  <= 1'b0;
      end
    end
  end

  // names start out as zero, a bad-length register keeps the old name
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) name_r[i] <= '0;
    end else if (state_r == ST_IDLE && cmd_take && cmd.kind == pess_pkg::KIND_REG &&
                 free_f && cmd.name_ok) begin
      name_r[free_i] <= cmd.name_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_NEXT && eligible) begin
      rem_r <= '0;
      bit_r <= 4'(CW - 1);
    end else if (state_r == ST_DIV) begin
      rem_r <= diff[PW] ? rsh[CW-1:0] : diff[CW-1:0];
      if (bit_r != '0) bit_r <= bit_r - 4'd1;
    end
    if (state_r == ST_IDLE && cmd_take && cmd.kind == pess_pkg::KIND_REG && free_f) begin
      per_r[free_i] <= cmd.period;
      hnd_r[free_i] <= cmd.handler_tag;
      out_r.fired <= 1'b0;
      out_r.slot <= SW'(free_i);
      out_r.handler <= '0;
      out_r.error_code <= cmd.name_ok ? pess_pkg::ERR_NONE : pess_pkg::ERR_BAD_NAME;
      out_r.last <= 1'b1;
    end else if (state_r == ST_IDLE && cmd_take && cmd.kind == pess_pkg::KIND_DEL) begin
      out_r.fired <= 1'b0;
      out_r.slot <= '0;
      out_r.handler <= '0;
      out_r.error_code <= (|hit) ? pess_pkg::ERR_NONE : pess_pkg::ERR_NOT_FND;
      out_r.last <= 1'b1;
    end else if (out_free && pend_r &&
                 ((state_r == ST_IDLE) ||
                  (state_r == ST_EMIT && ((eligible && divides) || last_idx)))) begin
      out_r.fired <= 1'b1;
      out_r.slot <= SW'(pend_idx_r);
      out_r.handler <= hnd_r[pend_idx_r];
      out_r.error_code <= pess_pkg::ERR_NONE;
      out_r.last <= !(state_r == ST_EMIT && eligible && divides);
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> (state_r == ST_IDLE && !pend_r)) else $error("take while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !res_pop) |=> (out_v_r && $stable(out_r))) else $error("result lost");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> (state_r == ST_IDLE)) else $error("cfg while busy");
endmodule

// File: rtl/core/periodic_event_slot_scheduler.sv
// top level of the periodic event slot scheduler
// Requests enter through a queue-style port: push with full, payload on in_ ports.
// Kind 0 ticks the counter, kind 1 registers into the lowest free slot, kind 2
// deletes every slot whose name matches. Results leave through a queue-style
// port: while empty is low the oldest result is on out_ ports, pop takes it.
// A two-entry request queue decouples the front end from the slot engine.
// Delete gives one result; register gives one unless no slot is free.
// A tick walks every slot in turn; each live slot with nonzero period adds
// a 14-step serial remainder and an emit step.
// Firings come out in slot order, the final one marked by out_last.
// The one-entry result register stalls the engine while pop stays low; the
// request queue then fills and full rises. No requests are lost.
// Reset clears all slots, the counter and the queue; wrap limit returns to 10000.
// cfg_wrap_limit is written on cfg_valid and cfg_ready, ready only while idle.
module periodic_event_slot_scheduler #(
  parameter int unsigned SLOTS = pess_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_name_tag,
  input  logic [7:0]  in_name_length,
  input  logic [15:0] in_period,
  input  logic [15:0] in_handler_tag,
  output logic        empty,
  input  logic        pop,
  output logic        out_fired,
  output logic [3:0]  out_slot,
  output logic [15:0] out_handler,
  output logic [1:0]  out_error_code,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_wrap_limit
);
  logic cmd_valid, cmd_take, res_valid;
  pess_pkg::cmd_t cmd;
  pess_pkg::res_t res;

  pess_front u_front (
    .clk, .rst_n, .push, .full, .in_kind, .in_name_tag, .in_name_length,
    .in_period, .in_handler_tag, .cmd_valid, .cmd_take, .cmd
  );

  pess_back #(.SLOTS(SLOTS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd, .cfg_valid, .cfg_ready,
    .cfg_wrap_limit, .res_valid, .res_pop(pop), .res
  );

  assign empty          = !res_valid;
  assign out_fired      = res.fired;
  assign out_slot       = res.slot;
  assign out_handler    = res.handler;
  assign out_error_code = res.error_code;
  assign out_last       = res.last;
endmodule

// File: dv/tb_periodic_event_slot_scheduler.sv
// testbench for the periodic event slot scheduler: queued stimulus, slot table prediction
`timescale 1ns / 100ps
module tb_periodic_event_slot_scheduler;

  typedef struct {
    pess_pkg::kind_t kind;
    logic [63:0]     name;
    logic [7:0]      len;
    logic [15:0]     per;
    logic [15:0]     hnd;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_kind = 2'd0;
  logic [63:0] in_name_tag = '0;
  logic [7:0]  in_name_length = '0;
  logic [15:0] in_period = '0;
  logic [15:0] in_handler_tag = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_fired;
  logic [3:0]  out_slot;
  logic [15:0] out_handler;
  logic [1:0]  out_error_code;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [13:0] cfg_wrap_limit = '0;

  periodic_event_slot_scheduler i_dut (.*);

  always #5 clk = ~clk;

  request_t       pending_requests[$];
  request_t       cur;
  pess_pkg::res_t expected_results[$];
  logic [63:0]    name_pool[6];
  int             errors = 0;
  int             send_gap = 0;
  int             pop_gap = 0;
  int             hold_off = 0;
  int             results_seen = 0;
  bit             no_idle = 1'b0;

  // scheduler state mirror
  bit          mdl_active[pess_pkg::SLOTS_DEF];
  logic [63:0] mdl_name[pess_pkg::SLOTS_DEF];
  logic [15:0] mdl_period[pess_pkg::SLOTS_DEF];
  logic [15:0] mdl_handler[pess_pkg::SLOTS_DEF];
  logic [13:0] mdl_count = '0;
  logic [13:0] mdl_wrap = pess_pkg::WRAP_RESET;

  function automatic pess_pkg::res_t make_res(logic f, int s, logic [15:0] h,
                                              pess_pkg::err_t e, logic l);
    pess_pkg::res_t r;
    r.fired = f;
    r.slot = s[3:0];
    r.handler = h;
    r.error_code = e;
    r.last = l;
    return r;
  endfunction

  task automatic schedule_request(request_t rq);
    int             n;
    int             free_slot;
    bit             found;
    pess_pkg::err_t e;
    n = 0;
    free_slot = -1;
    found = 0;
    case (rq.kind)
      pess_pkg::KIND_TICK: begin
        mdl_count = mdl_count + 14'd1;
        for (int i = 0; i < pess_pkg::SLOTS_DEF; i++) begin
          if (mdl_active[i] && mdl_period[i] != 0 &&
              (32'(mdl_count) % 32'(mdl_period[i])) == 0) begin
            expected_results.push_back(make_res(1'b1, i, mdl_handler[i],
                                                pess_pkg::ERR_NONE, 1'b0));
            n++;
          end
        end
        if (n > 0) expected_results[$].last = 1'b1;
        if (mdl_count >= mdl_wrap) mdl_count = '0;
      end
      pess_pkg::KIND_REG: begin
        for (int i = pess_pkg::SLOTS_DEF - 1; i >= 0; i--) begin
          if (!mdl_active[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
          e = pess_pkg::ERR_NONE;
          mdl_active[free_slot] = 1'b1;
          if (rq.len < pess_pkg::NAME_LIMIT) mdl_name[free_slot] = rq.name;
          else e = pess_pkg::ERR_BAD_NAME;
          mdl_period[free_slot] = rq.per;
          mdl_handler[free_slot] = rq.hnd;
          expected_results.push_back(make_res(1'b0, free_slot, 16'd0, e, 1'b1));
        end
      end
      pess_pkg::KIND_DEL: begin
        for (int i = 0; i < pess_pkg::SLOTS_DEF; i++) begin
          if (mdl_active[i] && mdl_name[i] == rq.name) begin
            mdl_active[i] = 1'b0;
            found = 1;
          end
        end
        expected_results.push_back(make_res(1'b0, 0, 16'd0,
                                            found ? pess_pkg::ERR_NONE :
                                                    pess_pkg::ERR_NOT_FND, 1'b1));
      end
      default: ;
    endcase
  endtask

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic add(pess_pkg::kind_t k, logic [63:0] nm, logic [7:0] ln, logic [15:0] p,
                     logic [15:0] h);
    request_t rq;
    rq.kind = k;
    rq.name = nm;
    rq.len = ln;
    rq.per = p;
    rq.hnd = h;
    pending_requests.push_back(rq);
  endtask

  task automatic add_random();
    int          sel;
    logic [63:0] nm;
    logic [7:0]  ln;
    logic [15:0] p;
    sel = $urandom_range(0, 99);
    nm = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : name_pool[$urandom_range(0, 5)];
    ln = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(31, 255)) : 8'($urandom_range(0, 30));
    case ($urandom_range(0, 9))
      0:       p = 16'd0;
      1, 2:    p = 16'($urandom);
      default: p = 16'($urandom_range(1, 8));
    endcase
    if (sel < 48) add(pess_pkg::KIND_TICK, {$urandom, $urandom}, 8'($urandom), 16'($urandom),
                      16'($urandom));
    else if (sel < 74) add(pess_pkg::KIND_REG, nm, ln, p, 16'($urandom));
    else if (sel < 95) add(pess_pkg::KIND_DEL, nm, 8'($urandom), 16'($urandom), 16'($urandom));
    else add(pess_pkg::KIND_NONE, nm, ln, p, 16'($urandom));
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || push || expected_results.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_wrap(logic [13:0] val);
    cfg_valid <= 1'b1;
    cfg_wrap_limit <= val;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    mdl_wrap = val;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        schedule_request(cur);
        send_gap = draw_gap();
        if (send_gap == 0 && pending_requests.size() != 0) begin
          cur = pending_requests.pop_front();
          in_kind <= cur.kind;
          in_name_tag <= cur.name;
          in_name_length <= cur.len;
          in_period <= cur.per;
          in_handler_tag <= cur.hnd;
        end else begin
          push <= 1'b0;
        end
      end else if (!push) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_requests.size() != 0) begin
          cur = pending_requests.pop_front();
          push <= 1'b1;
          in_kind <= cur.kind;
          in_name_tag <= cur.name;
          in_name_length <= cur.len;
          in_period <= cur.per;
          in_handler_tag <= cur.hnd;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    pess_pkg::res_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop && !empty) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual f=%0b s=%0d h=%h e=%0d l=%0b",
                 $time, out_fired, out_slot, out_handler, out_error_code, out_last);
      end else begin
        want = expected_results.pop_front();
        if (out_fired !== want.fired || out_slot !== want.slot ||
            out_handler !== want.handler || out_error_code !== want.error_code ||
            out_last !== want.last) begin
          errors++;
          $display("%0t: mismatch, expected f=%0b s=%0d h=%h e=%0d l=%0b,",
                   $time, want.fired, want.slot, want.handler, want.error_code, want.last,
                   " actual f=%0b s=%0d h=%h e=%0d l=%0b",
                   out_fired, out_slot, out_handler, out_error_code, out_last);
        end
      end
      pop_gap = draw_gap();
      if (results_seen == 30) hold_off = 400;
      if (results_seen != 30 && pop_gap == 0) pop <= 1'b1;
      else pop <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
    end else if (!pop) begin
      if (pop_gap > 0) pop_gap--;
      else pop <= 1'b1;
    end
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [13:0] wraps[5];
    for (int i = 0; i < pess_pkg::SLOTS_DEF; i++) begin
      mdl_active[i] = 1'b0;
      mdl_name[i] = '0;
      mdl_period[i] = '0;
      mdl_handler[i] = '0;
    end
    foreach (name_pool[i]) name_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: name and length extremes, zero period, full table, multi-match delete
    add(pess_pkg::KIND_REG, 64'd0, 8'd0, 16'd1, 16'h0000);
    add(pess_pkg::KIND_REG, '1, 8'd30, 16'hffff, 16'hffff);
    add(pess_pkg::KIND_REG, name_pool[0], 8'd31, 16'd2, 16'h1234);
    add(pess_pkg::KIND_REG, name_pool[1], 8'd255, 16'd0, 16'h5a5a);
    add(pess_pkg::KIND_REG, name_pool[1], 8'd5, 16'd3, 16'ha5a5);
    add(pess_pkg::KIND_TICK, '1, '1, '1, '1);
    add(pess_pkg::KIND_TICK, '0, '0, '0, '0);
    add(pess_pkg::KIND_DEL, name_pool[1], 8'd200, 16'd0, 16'd0);
    add(pess_pkg::KIND_DEL, name_pool[5], 8'd0, 16'd0, 16'd0);
    add(pess_pkg::KIND_NONE, '1, '1, '1, '1);
    for (int i = 0; i < 7; i++) begin
      add(pess_pkg::KIND_REG, name_pool[2 + i % 3], 8'(i), 16'(i + 1), 16'(i));
    end
    add(pess_pkg::KIND_TICK, '0, '0, '0, '0);
    add(pess_pkg::KIND_TICK, '0, '0, '0, '0);
    add(pess_pkg::KIND_DEL, 64'd0, 8'd0, 16'd0, 16'd0);
    add(pess_pkg::KIND_DEL, '1, 8'd0, 16'd0, 16'd0);
    repeat (30) add_random();

    wraps = '{14'd1, 14'd7, 14'd16383, 14'd30, 14'($urandom_range(2, 200))};
    foreach (wraps[p]) begin
      wait_idle();
      write_wrap(wraps[p]);
      no_idle = (p == 3);
      repeat (68) add_random();
    end

    do @(posedge clk);
    while (pending_requests.size() != 0 || push || expected_results.size() != 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
